>>> src/ptt_pkg.sv
// shared types and constants of the periodic task timer table
// no dependencies; imported by the core, by its checkers and by the testbench
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	// fixed field widths of the item ports
	localparam int ACTION_W     = 2;
	localparam int TIME_FIELD_W = 32;
	localparam int SLOT_ID_W    = 3;
	localparam int FIRED_W      = 8;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 4;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

	// result fields built up while an item is worked on
	typedef struct packed {
		logic [FIRED_W-1:0]   fired;
		logic [SLOT_ID_W-1:0] assigned;
		logic [STATUS_W-1:0]  status;
	} result_t;

endpackage

`default_nettype wire

>>> src/periodic_task_timer_table_core.sv
// periodic task timer table: slot table, scan sequencer and shared subtract unit
// depends on ptt_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//   request channel (req_valid / req_stall) carries one item: action, elapsed_ms,
//   period_ms, slot_id. response channel (rsp_valid / rsp_stall) returns one item
//   per request: fired_mask, assigned_slot, status, active_count.
//   an item is taken at a clock edge with valid high and stall low.
// timing
//   one item at a time; req_stall stays high from the accept edge until the
//   result has been moved into the output register.
//   tick: one subtract/compare unit walks the slots, one slot per cycle, behind
//   a registered read of the slot memories, then the result goes through the
//   done state into the output register.
//   add: the free-slot search checks one active bit per cycle, lowest slot first;
//   remove checks one active bit; an unused code goes straight to done.
// reset
//   arst_n clears all active marks, the task count and the sequencer; period and
//   remaining memories are not cleared since an inactive slot's contents are never used.
// back pressure
//   the output register holds its item while rsp_stall is high; a new request is
//   still taken, and its result waits in the done state until the register frees.

module periodic_task_timer_table_core #(
	parameter int NUM_SLOTS  = 8,
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [ptt_pkg::ACTION_W-1:0]     action,
	input  wire logic [ptt_pkg::TIME_FIELD_W-1:0] elapsed_ms,
	input  wire logic [ptt_pkg::TIME_FIELD_W-1:0] period_ms,
	input  wire logic [ptt_pkg::SLOT_ID_W-1:0]    slot_id,
	// response channel
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output logic [ptt_pkg::FIRED_W-1:0]           fired_mask,
	output logic [ptt_pkg::SLOT_ID_W-1:0]         assigned_slot,
	output logic [ptt_pkg::STATUS_W-1:0]          status,
	output logic [ptt_pkg::COUNT_W-1:0]           active_count
);
	import ptt_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TICK   = 3'd1;
	localparam logic [2:0] S_ADD    = 3'd2;
	localparam logic [2:0] S_REMOVE = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]           state_q;
	logic [IW-1:0]        idx_q;       // slot being read or searched
	logic                 issue_q;     // tick scan still issuing reads
	logic                 vld_s1;      // read data of idx_s1 is ready
	logic [IW-1:0]        idx_s1;
	logic [NUM_SLOTS-1:0] act_q;
	logic [CW-1:0]        count_q;
	result_t              res_q;
	logic                 rsp_valid_q;

	// captured request fields
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [TIME_WIDTH-1:0] period_q;
	logic [SLOT_ID_W-1:0]  slot_id_q;

	// output register
	logic [FIRED_W-1:0]   fired_mask_q;
	logic [SLOT_ID_W-1:0] assigned_slot_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_W-1:0]   active_count_q;

	// slot memories, one write and one registered read per cycle
	logic [TIME_WIDTH-1:0] per_mem [NUM_SLOTS];
	logic [TIME_WIDTH-1:0] rem_mem [NUM_SLOTS];
	logic [TIME_WIDTH-1:0] per_rd_s1;
	logic [TIME_WIDTH-1:0] rem_rd_s1;

	logic                  accept;
	logic                  out_free;
	logic [TIME_WIDTH:0]   diff;
	logic                  fire;
	logic                  tick_slot;
	logic                  add_hit;
	logic                  mem_we;
	logic [IW-1:0]         mem_wa;
	logic [TIME_WIDTH-1:0] mem_wdata;
	logic [FIRED_W-1:0]    fired_nxt;
	logic [IW-1:0]         rem_idx;
	logic                  rem_ok;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// shared unit: remaining minus elapsed, borrow or zero means the slot fires
	assign diff = {1'b0, rem_rd_s1} - {1'b0, elapsed_q};
	assign fire = diff[TIME_WIDTH] || (diff[TIME_WIDTH-1:0] == '0);

	assign tick_slot = (state_q == S_TICK) && vld_s1 && act_q[idx_s1];
	assign add_hit   = (state_q == S_ADD) && !act_q[idx_q];

	// add loads both memories at the found slot; tick writes back the new count
	assign mem_we    = tick_slot || add_hit;
	assign mem_wa    = (state_q == S_ADD) ? idx_q : idx_s1;
	assign mem_wdata = add_hit ? period_q : (fire ? per_rd_s1 : diff[TIME_WIDTH-1:0]);

	// remove: slot numbers past the table are refused
	assign rem_idx = IW'(slot_id_q);
	assign rem_ok  = (32'(slot_id_q) < NUM_SLOTS) && act_q[rem_idx];

	// slots above the mask width never show
	always_comb begin
		fired_nxt = res_q.fired;
		for (int b = 0; b < FIRED_W; b++) begin
			if (tick_slot && fire && (32'(idx_s1) == b)) begin
				fired_nxt[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rem_mem[mem_wa] <= mem_wdata;
		end
		if (add_hit) begin
			per_mem[mem_wa] <= period_q;
		end
		rem_rd_s1 <= rem_mem[idx_q];
		per_rd_s1 <= per_mem[idx_q];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= TIME_WIDTH'(elapsed_ms);
			period_q  <= TIME_WIDTH'(period_ms);
			slot_id_q <= slot_id;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			act_q       <= '0;
			count_q     <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_TICK) && issue_q;
			idx_s1 <= idx_q;
			// set when the result moves out, cleared once taken
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q        <= '0;
						res_q.fired  <= '0;
						res_q.assigned <= '0;
						res_q.status <= ST_OK;
						case (action)
							ACT_TICK: begin
								issue_q <= 1'b1;
								state_q <= S_TICK;
							end
							ACT_ADD:    state_q <= S_ADD;
							ACT_REMOVE: state_q <= S_REMOVE;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_TICK: begin
					if (issue_q) begin
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					res_q.fired <= fired_nxt;
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= S_DONE;
					end
				end
				S_ADD: begin
					if (!act_q[idx_q]) begin
						act_q[idx_q]   <= 1'b1;
						count_q        <= count_q + 1'b1;
						res_q.assigned <= SLOT_ID_W'(idx_q);
						state_q        <= S_DONE;
					end else if (idx_q == LAST_IDX) begin
						res_q.status <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REMOVE: begin
					if (rem_ok) begin
						act_q[rem_idx] <= 1'b0;
						count_q        <= count_q - 1'b1;
					end else begin
						res_q.status <= ST_NOT_ACTIVE;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, loaded only when free so a stalled item holds
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			fired_mask_q    <= res_q.fired;
			assigned_slot_q <= res_q.assigned;
			status_q        <= res_q.status;
			active_count_q  <= COUNT_W'(count_q);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign fired_mask    = fired_mask_q;
	assign assigned_slot = assigned_slot_q;
	assign status        = status_q;
	assign active_count  = active_count_q;

endmodule

`default_nettype wire

>>> src/ptt_chk.sv
// port-level checks of the periodic task timer table core, with its bind
// depends on ptt_pkg and periodic_task_timer_table_core
`timescale 1ns / 1ps
`default_nettype none

module ptt_chk #(
	parameter int NUM_SLOTS = 8
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_stall,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_stall,
	input wire logic [ptt_pkg::FIRED_W-1:0]      fired_mask,
	input wire logic [ptt_pkg::SLOT_ID_W-1:0]    assigned_slot,
	input wire logic [ptt_pkg::STATUS_W-1:0]     status,
	input wire logic [ptt_pkg::COUNT_W-1:0]      active_count
);
	import ptt_pkg::*;

	// a stalled response item stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(fired_mask)
			&& $stable(assigned_slot) && $stable(status) && $stable(active_count))
		else $error("response item changed while stalled");

	// one item at a time: the block stalls right after taking one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while an item is in progress");

	// only a tick fires slots, and a tick assigns nothing
	a_fire_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (fired_mask != '0) |-> (status == ST_OK) && (assigned_slot == '0))
		else $error("fired slots on a non-tick result");

	// a full table reports every slot active
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL)
			|-> (assigned_slot == '0) && (active_count == COUNT_W'(NUM_SLOTS)))
		else $error("full status with a free slot left");

	// count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (NUM_SLOTS >= 16) || (32'(active_count) <= NUM_SLOTS))
		else $error("active count above table size");

endmodule

bind periodic_task_timer_table_core ptt_chk #(.NUM_SLOTS(NUM_SLOTS)) u_ptt_chk (.*);

`default_nettype wire

>>> tb/sv/timer_table_check.sv
// result checker for the periodic task timer table: watches both channels, keeps its
// own slot table, works out each item's outcome and compares it with the block's result
// depends on ptt_pkg
`timescale 1ns / 1ps

module timer_table_check (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	input  wire logic                             req_stall,
	input  wire logic [ptt_pkg::ACTION_W-1:0]     action,
	input  wire logic [ptt_pkg::TIME_FIELD_W-1:0] elapsed_ms,
	input  wire logic [ptt_pkg::TIME_FIELD_W-1:0] period_ms,
	input  wire logic [ptt_pkg::SLOT_ID_W-1:0]    slot_id,
	input  wire logic                             rsp_valid,
	input  wire logic                             rsp_stall,
	input  wire logic [ptt_pkg::FIRED_W-1:0]      fired_mask,
	input  wire logic [ptt_pkg::SLOT_ID_W-1:0]    assigned_slot,
	input  wire logic [ptt_pkg::STATUS_W-1:0]     status,
	input  wire logic [ptt_pkg::COUNT_W-1:0]      active_count,
	output int                                    failures,
	output int                                    outstanding,
	output int                                    results_checked,
	output int                                    firings
);
	import ptt_pkg::*;

	localparam int SLOTS = 8;

	typedef struct packed {
		logic [FIRED_W-1:0]   fired;
		logic [SLOT_ID_W-1:0] assigned;
		logic [STATUS_W-1:0]  status;
		logic [COUNT_W-1:0]   count;
	} outcome_t;

	// shadow slot table
	logic [TIME_FIELD_W-1:0] slot_period [SLOTS];
	logic [TIME_FIELD_W-1:0] slot_left [SLOTS];
	logic                    slot_on [SLOTS];
	logic [COUNT_W-1:0]      live_count;

	outcome_t pending_outcomes [$];

	// applies one item to the shadow table and returns what the block must answer
	function automatic outcome_t advance_table(
		input logic [ACTION_W-1:0]     act,
		input logic [TIME_FIELD_W-1:0] elapsed,
		input logic [TIME_FIELD_W-1:0] period,
		input logic [SLOT_ID_W-1:0]    id
	);
		outcome_t o;
		bit placed;
		o = '0;
		placed = 1'b0;
		case (act)
			ACT_TICK: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_on[s]) begin
						if (elapsed >= slot_left[s]) begin
							o.fired[s] = 1'b1;
							slot_left[s] = slot_period[s];
						end else begin
							slot_left[s] = slot_left[s] - elapsed;
						end
					end
				end
			end
			ACT_ADD: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (!placed && !slot_on[s]) begin
						slot_on[s] = 1'b1;
						slot_period[s] = period;
						slot_left[s] = period;
						o.assigned = SLOT_ID_W'(s);
						live_count = live_count + 1'b1;
						placed = 1'b1;
					end
				end
				if (!placed)
					o.status = ST_FULL;
			end
			ACT_REMOVE: begin
				if (slot_on[id]) begin
					slot_on[id] = 1'b0;
					slot_period[id] = '0;
					slot_left[id] = '0;
					live_count = live_count - 1'b1;
				end else begin
					o.status = ST_NOT_ACTIVE;
				end
			end
			default: ;
		endcase
		o.count = live_count;
		return o;
	endfunction

	task automatic note_mismatch(input string what, input int got_v, input int want_v);
		failures++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				slot_period[s] = '0;
				slot_left[s] = '0;
				slot_on[s] = 1'b0;
			end
			live_count = '0;
			pending_outcomes.delete();
			failures = 0;
			outstanding = 0;
			results_checked = 0;
			firings = 0;
		end else begin
			// results first, so an item taken at this edge is never matched at it
			if (rsp_valid && !rsp_stall) begin
				results_checked++;
				firings += $countones(fired_mask);
				if (pending_outcomes.size() == 0) begin
					note_mismatch("result with nothing pending", results_checked, 0);
				end else begin
					want = pending_outcomes.pop_front();
					if (fired_mask !== want.fired)
						note_mismatch("fired_mask", fired_mask, want.fired);
					if (assigned_slot !== want.assigned)
						note_mismatch("assigned_slot", assigned_slot, want.assigned);
					if (status !== want.status)
						note_mismatch("status", status, want.status);
					if (active_count !== want.count)
						note_mismatch("active_count", active_count, want.count);
				end
			end
			if (req_valid && !req_stall)
				pending_outcomes.push_back(advance_table(action, elapsed_ms, period_ms, slot_id));
			outstanding = pending_outcomes.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// top of the timer table testbench: clock, reset, item stimulus, result back pressure,
// watchdog and verdict; depends on ptt_pkg, periodic_task_timer_table_core and
// timer_table_check
`timescale 1ns / 1ps

module testbench;
	import ptt_pkg::*;

	// the block ignores this code, so it is named here only
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	// cycles with nothing moving on either channel before the run is given up
	localparam int IDLE_LIMIT = 2000;
	// one long receiver hold so the block fills up and stalls its input
	localparam int LONG_HOLD = 300;
	localparam int LONG_HOLD_AT = 500;
	localparam int RANDOM_ITEMS = 1680;
	// quiet tail after the last result has been checked, before the verdict
	localparam int TAIL_CYCLES = 40;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic [ACTION_W-1:0]     action;
	logic [TIME_FIELD_W-1:0] elapsed_ms;
	logic [TIME_FIELD_W-1:0] period_ms;
	logic [SLOT_ID_W-1:0]    slot_id;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic [FIRED_W-1:0]      fired_mask;
	logic [SLOT_ID_W-1:0]    assigned_slot;
	logic [STATUS_W-1:0]     status;
	logic [COUNT_W-1:0]      active_count;

	int failures;
	int outstanding;
	int results_checked;
	int firings;

	int sent_by_action [4] = '{default: 0};
	bit send_quiet = 1'b0;
	int idle_cycles = 0;

	periodic_task_timer_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.elapsed_ms   (elapsed_ms),
		.period_ms    (period_ms),
		.slot_id      (slot_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.fired_mask   (fired_mask),
		.assigned_slot(assigned_slot),
		.status       (status),
		.active_count (active_count)
	);

	timer_table_check table_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.action         (action),
		.elapsed_ms     (elapsed_ms),
		.period_ms      (period_ms),
		.slot_id        (slot_id),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.fired_mask     (fired_mask),
		.assigned_slot  (assigned_slot),
		.status         (status),
		.active_count   (active_count),
		.failures       (failures),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.firings        (firings)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short times so slots fire often, now and then zero, the top end or anything
	function automatic logic [TIME_FIELD_W-1:0] pick_time(input int unsigned usual_max);
		case ($urandom_range(0, 15))
			0: pick_time = $urandom;
			1: pick_time = {TIME_FIELD_W{1'b1}} - $urandom_range(0, 2);
			2: pick_time = '0;
			default: pick_time = $urandom_range(0, usual_max);
		endcase
	endfunction

	// offers one item after a random gap and returns at the edge that takes it;
	// valid is set once per edge, so back-to-back items never drop it in between
	task automatic send_item(
		input logic [ACTION_W-1:0]     act,
		input logic [TIME_FIELD_W-1:0] elapsed,
		input logic [TIME_FIELD_W-1:0] period,
		input logic [SLOT_ID_W-1:0]    id
	);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		elapsed_ms <= elapsed;
		period_ms <= period;
		slot_id <= id;
		// payload stays put until the block lets go of its stall
		do @(posedge clk); while (req_stall);
		sent_by_action[act]++;
	endtask

	// receiver: a random wait after every result, quiet stretches, one long hold
	initial begin : receiver
		int wait_cycles;
		int taken;
		bit take_quiet;
		taken = 0;
		take_quiet = 1'b0;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				taken++;
				if (taken % 60 == 0)
					take_quiet = ($urandom_range(0, 3) == 0);
				if (taken == LONG_HOLD_AT)
					wait_cycles = LONG_HOLD;
				else
					wait_cycles = take_quiet ? 0 : $urandom_range(0, 19);
				if (wait_cycles > 0) begin
					rsp_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// watchdog: counts edges at which no item moves on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles, %0d results still pending",
					idle_cycles, outstanding);
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int roll;
		bit filling;
		logic [ACTION_W-1:0] act;
		filling = 1'b1;

		// every input known from time zero, reset held low at the start
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		action <= ACT_TICK;
		elapsed_ms <= '0;
		period_ms <= '0;
		slot_id <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, bad remove, unused code with every field bit set
		send_item(ACT_TICK, 32'd0, 32'd0, 3'd0);
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd0);
		send_item(ACT_UNUSED, '1, '1, '1);
		// zero period fires even on a zero-length tick
		send_item(ACT_ADD, 32'd0, 32'd0, 3'd0);
		send_item(ACT_TICK, 32'd0, 32'd0, 3'd0);
		// fill the table: top-end period, then a spread of short ones
		send_item(ACT_ADD, 32'd0, '1, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd5, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd1, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd3, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd100, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd2, 3'd0);
		send_item(ACT_ADD, 32'd0, 32'd7, 3'd0);
		// table full
		send_item(ACT_ADD, 32'd0, 32'd9, 3'd0);
		// exact hit, overshoot dropped on reload, then every slot at once
		send_item(ACT_TICK, 32'd3, 32'd0, 3'd0);
		send_item(ACT_TICK, '1, 32'd0, 3'd0);
		// a hole in the middle is the lowest free slot
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd3);
		send_item(ACT_ADD, 32'd0, 32'd10, 3'd0);
		// top slot removed twice, second time it is already gone
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd7);
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd7);
		send_item(ACT_TICK, 32'd1, 32'd0, 3'd0);
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd1);
		send_item(ACT_REMOVE, 32'd0, 32'd0, 3'd0);
		send_item(ACT_TICK, 32'd4, 32'd0, 3'd0);

		// random: blocks that lean toward filling or draining the table,
		// with every field random whether the action uses it or not
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				send_quiet = ($urandom_range(0, 3) == 0);
				filling = ($urandom_range(0, 1) == 1);
			end
			roll = $urandom_range(0, 99);
			if (roll < 45)
				act = ACT_TICK;
			else if (roll < (filling ? 85 : 60))
				act = ACT_ADD;
			else if (roll < 96)
				act = ACT_REMOVE;
			else
				act = ACT_UNUSED;
			send_item(act, pick_time(12), pick_time(40), SLOT_ID_W'($urandom_range(0, 7)));
		end
		req_valid <= 1'b0;

		// drain: the watchdog covers a result that never shows up
		@(posedge clk);
		wait (outstanding == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d items: %0d ticks, %0d adds, %0d removes, %0d with the unused code",
			sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
			sent_by_action[ACT_TICK], sent_by_action[ACT_ADD], sent_by_action[ACT_REMOVE],
			sent_by_action[ACT_UNUSED]);
		$display("checked %0d results with %0d slot firings, %0d mismatches, %0d left pending",
			results_checked, firings, failures, outstanding);
		if (failures == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
